@@ hdl/cbt_pkg.sv @@
`default_nettype none
package cbt_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 5;

	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;

	typedef logic [OFFSET_BITS-1:0] off_t;

	typedef enum logic [3:0] {
		K_WS  = 4'd0,
		K_PRE = 4'd1,
		K_COM = 4'd2,
		K_PUN = 4'd3,
		K_UNK = 4'd4,
		K_ID  = 4'd5,
		K_NUM = 4'd6,
		K_STR = 4'd7,
		K_CHR = 4'd8,
		K_ERR = 4'd9
	} kind_t;

	typedef enum logic [3:0] {
		M_IDLE,
		M_WS,
		M_PRE,
		M_LCOM,
		M_BCOM,
		M_STR,
		M_CHR,
		M_ID,
		M_NUM,
		M_SLASH
	} mode_t;

	typedef struct packed {
		kind_t kind;
		off_t  start;
		off_t  len;
	} tok_t;

	// tokens caused by one input byte
	typedef struct packed {
		logic two;
		logic tfin;
		tok_t t0;
		tok_t t1;
	} pair_t;

	function automatic logic [31:0] field32(input off_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		logic r;
		case (c)
			8'h7E, 8'h21, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29, 8'h2D, 8'h2B,
			8'h3D, 8'h7B, 8'h5B, 8'h7D, 8'h5D, 8'h7C, 8'h3A, 8'h3B, 8'h3C, 8'h2C,
			8'h3E, 8'h2E, 8'h3F: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hdl/cbt_front.sv @@
`default_nettype none
module cbt_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [cbt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] source_byte
	input  wire                              s_axis_tlast,  // end_of_text
	input  wire                              q_full,
	output logic                             q_push,
	output cbt_pkg::pair_t                   q_wdata
);
	import cbt_pkg::*;

	mode_t mode_q, n_mode;
	off_t  start_q, n_start;
	off_t  len_q, n_len;
	off_t  pos_q, n_pos;
	logic  ls_q, n_ls;
	logic  esc_q, n_esc;
	logic  star_q, n_star;

	logic [7:0] c;
	logic       last, accept, disp;
	logic       is_sp, is_nl;
	off_t       len_inc;
	logic [7:0] quote;
	kind_t      qkind;

	logic  ea_v, eb_v, ec_v;
	kind_t ea_kind, eb_kind, ec_kind;
	off_t  ea_start, ea_len, ec_start, ec_len;

	assign c      = s_axis_tdata;
	assign last   = s_axis_tlast;
	assign s_axis_tready = !q_full;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign is_sp  = (c == CH_SP) || (c == CH_TAB);
	assign is_nl  = (c == CH_NL);
	assign len_inc = (len_q == '1) ? len_q : off_t'(len_q + 1'b1);
	assign quote  = (mode_q == M_STR) ? CH_DQ : CH_SQ;
	assign qkind  = (mode_q == M_STR) ? K_STR : K_CHR;

	// next state: mode step, then dispatch of the byte, then end-of-text flush
	always_comb begin
		n_mode = mode_q;
		n_start = start_q;
		n_len = len_q;
		n_ls = ls_q;
		n_esc = esc_q;
		n_star = star_q;
		n_pos = off_t'(pos_q + 1'b1);
		disp = 1'b0;
		ea_v = 1'b0;
		ea_kind = K_WS;
		eb_v = 1'b0;
		eb_kind = K_PUN;
		ec_v = 1'b0;
		ec_kind = K_WS;
		case (mode_q)
			M_WS: begin
				if (is_sp) begin
					n_len = len_inc;
				end else if (is_nl) begin
					n_len = len_inc;
					n_ls = 1'b1;
				end else begin
					ea_v = 1'b1;
					ea_kind = K_WS;
					n_mode = M_IDLE;
					disp = 1'b1;
				end
			end
			M_PRE: begin
				n_len = len_inc;
				if (esc_q) begin
					n_esc = 1'b0;
				end else if (c == CH_BSL) begin
					n_esc = 1'b1;
				end else if (is_nl) begin
					ea_v = 1'b1;
					ea_kind = K_PRE;
					n_mode = M_IDLE;
				end
			end
			M_LCOM: begin
				n_len = len_inc;
				if (is_nl) begin
					ea_v = 1'b1;
					ea_kind = K_COM;
					n_mode = M_IDLE;
					n_ls = 1'b1;
				end
			end
			M_BCOM: begin
				n_len = len_inc;
				if (star_q && c == CH_SLASH) begin
					ea_v = 1'b1;
					ea_kind = K_COM;
					n_mode = M_IDLE;
				end else begin
					n_star = (c == CH_STAR);
				end
			end
			M_STR, M_CHR: begin
				if (esc_q) begin
					n_len = len_inc;
					n_esc = 1'b0;
				end else if (c == quote) begin
					n_len = len_inc;
					ea_v = 1'b1;
					ea_kind = qkind;
					n_mode = M_IDLE;
				end else if (c == CH_BSL) begin
					n_len = len_inc;
					n_esc = 1'b1;
				end else if (is_nl) begin
					// unterminated literal: bytes before the newline
					ea_v = 1'b1;
					ea_kind = K_ERR;
					n_mode = M_IDLE;
					disp = 1'b1;
				end else begin
					n_len = len_inc;
				end
			end
			M_ID, M_NUM: begin
				if (is_letter(c) || is_digit(c)) begin
					n_len = len_inc;
				end else begin
					ea_v = 1'b1;
					ea_kind = (mode_q == M_ID) ? K_ID : K_NUM;
					n_mode = M_IDLE;
					disp = 1'b1;
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					n_len = len_inc;
					n_mode = M_LCOM;
				end else if (c == CH_STAR) begin
					n_len = len_inc;
					n_mode = M_BCOM;
					n_star = 1'b0;
				end else begin
					ea_v = 1'b1;
					ea_kind = K_PUN;
					n_ls = 1'b0;
					n_mode = M_IDLE;
					disp = 1'b1;
				end
			end
			default: begin
				disp = 1'b1;
			end
		endcase
		ea_start = start_q;
		ea_len = n_len;

		if (disp) begin
			n_start = pos_q;
			n_len = off_t'(1);
			n_esc = 1'b0;
			n_star = 1'b0;
			if (is_sp || is_nl) begin
				n_mode = M_WS;
				if (is_nl) begin
					n_ls = 1'b1;
				end
			end else if (c == CH_HASH && n_ls) begin
				n_mode = M_PRE;
			end else if (c == CH_SLASH) begin
				n_mode = M_SLASH;
			end else if (is_digit(c)) begin
				n_mode = M_NUM;
				n_ls = 1'b0;
			end else if (is_letter(c)) begin
				n_mode = M_ID;
				n_ls = 1'b0;
			end else if (c == CH_DQ) begin
				n_mode = M_STR;
				n_ls = 1'b0;
			end else if (c == CH_SQ) begin
				n_mode = M_CHR;
				n_ls = 1'b0;
			end else begin
				eb_v = 1'b1;
				eb_kind = (c == CH_HASH || is_punct(c)) ? K_PUN : K_UNK;
				n_ls = 1'b0;
				n_mode = M_IDLE;
			end
		end

		ec_start = n_start;
		ec_len = n_len;
		if (last) begin
			ec_v = (n_mode != M_IDLE);
			case (n_mode)
				M_WS:    ec_kind = K_WS;
				M_PRE:   ec_kind = K_PRE;
				M_LCOM:  ec_kind = K_COM;
				M_ID:    ec_kind = K_ID;
				M_NUM:   ec_kind = K_NUM;
				M_SLASH: ec_kind = K_PUN;
				default: ec_kind = K_ERR;
			endcase
			n_mode = M_IDLE;
			n_start = '0;
			n_len = '0;
			n_pos = '0;
			n_ls = 1'b1;
			n_esc = 1'b0;
			n_star = 1'b0;
		end
	end

	// outputs: pack the up to two tokens in order
	always_comb begin
		q_wdata.tfin = last;
		q_wdata.t0 = '{kind: ec_kind, start: ec_start, len: ec_len};
		q_wdata.t1 = '{kind: ec_kind, start: ec_start, len: ec_len};
		q_wdata.two = 1'b0;
		if (ea_v) begin
			q_wdata.t0 = '{kind: ea_kind, start: ea_start, len: ea_len};
			q_wdata.two = eb_v || ec_v;
			if (eb_v) begin
				q_wdata.t1 = '{kind: eb_kind, start: pos_q, len: off_t'(1)};
			end
		end else if (eb_v) begin
			q_wdata.t0 = '{kind: eb_kind, start: pos_q, len: off_t'(1)};
			q_wdata.two = ec_v;
		end
		q_push = accept && (ea_v || eb_v || ec_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			start_q <= '0;
			len_q <= '0;
			pos_q <= '0;
			ls_q <= 1'b1;
			esc_q <= 1'b0;
			star_q <= 1'b0;
		end else if (accept) begin
			mode_q <= n_mode;
			start_q <= n_start;
			len_q <= n_len;
			pos_q <= n_pos;
			ls_q <= n_ls;
			esc_q <= n_esc;
			star_q <= n_star;
		end
	end

endmodule
`default_nettype wire

@@ hdl/cbt_fifo.sv @@
`default_nettype none
module cbt_fifo (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  cbt_pkg::pair_t  wdata,
	input  wire             pop,
	output cbt_pkg::pair_t  rdata,
	output logic            full,
	output logic            empty
);
	import cbt_pkg::*;

	pair_t            mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(wr_q + 1'b1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(rd_q + 1'b1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= CNT_W'(cnt_q + 1'b1);
				2'b01:   cnt_q <= CNT_W'(cnt_q - 1'b1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("pop from empty queue");
	a_fill_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> !empty)
		else $error("queue empty after a write");

endmodule
`default_nettype wire

@@ hdl/cbt_back.sv @@
`default_nettype none
module cbt_back (
	input  wire                              clk,
	input  wire                              arst_n,
	input  cbt_pkg::pair_t                   head,
	input  wire                              empty,
	output logic                             pop,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [cbt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [31:0] token_start, [63:32] token_length
	output logic [cbt_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // [3:0] token_kind, [4] text_final
	output logic                             m_axis_tlast   // run_final
);
	import cbt_pkg::*;

	logic                  sel_q, load, take, fin;
	tok_t                  tok;
	logic [OUT_DATA_W-1:0] data_q;
	logic [OUT_USER_W-1:0] user_q;
	logic                  last_q, valid_q;

	assign load = !valid_q || m_axis_tready;
	assign take = load && !empty;
	assign fin  = sel_q || !head.two;
	assign pop  = take && fin;
	assign tok  = sel_q ? head.t1 : head.t0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= !empty;
			end
			if (take) begin
				sel_q <= !fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= {field32(tok.len), field32(tok.start)};
			user_q <= {fin && head.tfin, tok.kind};
			last_q <= fin;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = data_q;
	assign m_axis_tuser  = user_q;
	assign m_axis_tlast  = last_q;

	a_sel_has_entry: assert property (@(posedge clk) disable iff (!arst_n) sel_q |-> !empty)
		else $error("second token pending with empty queue");
	a_pair_split: assert property (@(posedge clk) disable iff (!arst_n)
		(take && head.two && !sel_q) |=> sel_q)
		else $error("two-token entry not split");
	a_text_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[4]) |-> m_axis_tlast)
		else $error("text end without run end");

endmodule
`default_nettype wire

@@ hdl/c_subset_byte_tokenizer.sv @@
// Channel  Dir  tdata                              tuser                  tlast
// s_axis   in   [7:0] source_byte                  -                      end_of_text
// m_axis   out  [31:0] token_start, [63:32] length [3:0] kind, [4] text_final  run_final
//
// One source byte per cycle unless the queue is full; the scan state updates in the same cycle a beat is taken.
// A byte that closes two tokens goes out as two beats; the back end sends one token per cycle unless m_axis stalls.
// Front and back are parted by a 4-entry queue, so a stalled output holds input only when full.
// An input beat reaches m_axis through a queue entry and then the back end's output register.
// Reset is asynchronous; no clearing pass, the block is ready right after reset.
`default_nettype none
module c_subset_byte_tokenizer (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire  [cbt_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] source_byte
	input  wire                              s_axis_tlast,  // end_of_text
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	output logic [cbt_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [31:0] token_start, [63:32] token_length
	output logic [cbt_pkg::OUT_USER_W-1:0]   m_axis_tuser,  // [3:0] token_kind, [4] text_final
	output logic                             m_axis_tlast   // run_final
);
	import cbt_pkg::*;

	pair_t q_wdata, q_rdata;
	logic  q_push, q_pop, q_full, q_empty;

	cbt_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_wdata       (q_wdata)
	);

	cbt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	cbt_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (q_rdata),
		.empty         (q_empty),
		.pop           (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
module testbench;
	import cbt_pkg::*;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} src_beat_t;

	typedef struct {
		kind_t kind;
		off_t  start;
		off_t  len;
		logic  run_end;
		logic  text_end;
	} token_t;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_STALL = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic in_last = 1'b0;
	logic out_ready = 1'b0;

	wire s_ready;
	wire m_valid;
	wire m_last;
	wire [OUT_DATA_W-1:0] m_data;
	wire [OUT_USER_W-1:0] m_user;

	src_beat_t  src_q[$];     // bytes waiting to be offered
	token_t     tok_q[$];     // predicted tokens, oldest first
	token_t     step_toks[$];
	logic [7:0] txt[$];       // text under construction

	int err_count = 0;
	int queued_beats = 0;
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	bit long_stall_go = 1'b0;
	bit stall_taken = 1'b0;
	int stall_left = 0;
	int quiet = 0;

	// scanner state
	mode_t lx_mode;
	off_t  lx_start;
	off_t  lx_pos;
	off_t  lx_len;
	logic  lx_line_head;
	logic  lx_escape;
	logic  lx_star;

	c_subset_byte_tokenizer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(in_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata (in_byte),
		.s_axis_tlast (in_last),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(out_ready),
		.m_axis_tdata (m_data),
		.m_axis_tuser (m_user),
		.m_axis_tlast (m_last)
	);

	always #2 clk = ~clk;

	function automatic logic digit_byte(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic alpha_byte(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
	endfunction

	function automatic logic punct_byte(input logic [7:0] c);
		logic r;
		case (c)
			"~", "!", "%", "^", "&", "*", "(", ")", "-", "+", "=", "{",
			"[", "}", "]", "|", ":", ";", "<", ",", ">", ".", "?": r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	task automatic lexer_reset();
		lx_mode = M_IDLE;
		lx_start = '0;
		lx_pos = '0;
		lx_len = '0;
		lx_line_head = 1'b1;
		lx_escape = 1'b0;
		lx_star = 1'b0;
	endtask

	task automatic put_token(input kind_t k, input off_t s, input off_t n);
		token_t t;
		t.kind = k;
		t.start = s;
		t.len = n;
		t.run_end = 1'b0;
		t.text_end = 1'b0;
		if (step_toks.size() < 2)
			step_toks.push_back(t);
	endtask

	task automatic lx_grow();
		if (lx_len != '1)
			lx_len = lx_len + 1'b1;
	endtask

	task automatic lx_close(input kind_t k);
		put_token(k, lx_start, lx_len);
		lx_mode = M_IDLE;
	endtask

	task automatic lx_open(input mode_t m, input off_t p);
		lx_mode = m;
		lx_start = p;
		lx_len = 1;
		lx_escape = 1'b0;
		lx_star = 1'b0;
	endtask

	// a byte seen between tokens
	task automatic lx_first(input logic [7:0] c, input off_t p);
		if (c == CH_SP || c == CH_TAB || c == CH_NL) begin
			lx_open(M_WS, p);
			if (c == CH_NL)
				lx_line_head = 1'b1;
		end else if (c == CH_HASH && lx_line_head) begin
			lx_open(M_PRE, p);
		end else if (c == CH_SLASH) begin
			lx_open(M_SLASH, p);
		end else if (digit_byte(c)) begin
			lx_open(M_NUM, p);
			lx_line_head = 1'b0;
		end else if (alpha_byte(c)) begin
			lx_open(M_ID, p);
			lx_line_head = 1'b0;
		end else if (c == CH_DQ) begin
			lx_open(M_STR, p);
			lx_line_head = 1'b0;
		end else if (c == CH_SQ) begin
			lx_open(M_CHR, p);
			lx_line_head = 1'b0;
		end else begin
			put_token((c == CH_HASH || punct_byte(c)) ? K_PUN : K_UNK, p, 1);
			lx_line_head = 1'b0;
			lx_mode = M_IDLE;
		end
	endtask

	task automatic lx_quoted(input logic [7:0] c, input off_t p, input logic [7:0] q,
			input kind_t k);
		if (lx_escape) begin
			lx_grow();
			lx_escape = 1'b0;
		end else if (c == q) begin
			lx_grow();
			lx_close(k);
		end else if (c == CH_BSL) begin
			lx_grow();
			lx_escape = 1'b1;
		end else if (c == CH_NL) begin
			// newline breaks the literal, then opens whitespace
			lx_close(K_ERR);
			lx_first(c, p);
		end else begin
			lx_grow();
		end
	endtask

	// advance the scanner by one byte and queue the tokens it closes
	task automatic lex_byte(input logic [7:0] c, input logic eot);
		off_t p;
		token_t t;
		p = lx_pos;
		step_toks.delete();
		case (lx_mode)
			M_WS: begin
				if (c == CH_SP || c == CH_TAB) begin
					lx_grow();
				end else if (c == CH_NL) begin
					lx_grow();
					lx_line_head = 1'b1;
				end else begin
					lx_close(K_WS);
					lx_first(c, p);
				end
			end
			M_PRE: begin
				lx_grow();
				if (lx_escape)
					lx_escape = 1'b0;
				else if (c == CH_BSL)
					lx_escape = 1'b1;
				else if (c == CH_NL)
					lx_close(K_PRE);
			end
			M_LCOM: begin
				lx_grow();
				if (c == CH_NL) begin
					lx_close(K_COM);
					lx_line_head = 1'b1;
				end
			end
			M_BCOM: begin
				lx_grow();
				if (lx_star && c == CH_SLASH)
					lx_close(K_COM);
				else
					lx_star = (c == CH_STAR);
			end
			M_STR: lx_quoted(c, p, CH_DQ, K_STR);
			M_CHR: lx_quoted(c, p, CH_SQ, K_CHR);
			M_ID, M_NUM: begin
				if (alpha_byte(c) || digit_byte(c)) begin
					lx_grow();
				end else begin
					lx_close((lx_mode == M_ID) ? K_ID : K_NUM);
					lx_first(c, p);
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					lx_grow();
					lx_mode = M_LCOM;
				end else if (c == CH_STAR) begin
					lx_grow();
					lx_mode = M_BCOM;
					lx_star = 1'b0;
				end else begin
					put_token(K_PUN, lx_start, 1);
					lx_line_head = 1'b0;
					lx_mode = M_IDLE;
					lx_first(c, p);
				end
			end
			default: lx_first(c, p);
		endcase
		lx_pos = lx_pos + 1'b1;

		if (eot) begin
			case (lx_mode)
				M_IDLE: ;
				M_WS: lx_close(K_WS);
				M_PRE: lx_close(K_PRE);
				M_LCOM: lx_close(K_COM);
				M_ID: lx_close(K_ID);
				M_NUM: lx_close(K_NUM);
				M_SLASH: lx_close(K_PUN);
				default: lx_close(K_ERR);
			endcase
		end

		if (step_toks.size() > 0) begin
			t = step_toks.pop_back();
			t.run_end = 1'b1;
			t.text_end = eot;
			step_toks.push_back(t);
		end
		foreach (step_toks[i])
			tok_q.push_back(step_toks[i]);
		if (eot)
			lexer_reset();
	endtask

	function automatic logic [7:0] rand_letter();
		int n;
		n = $urandom_range(0, 52);
		if (n < 26)
			return 8'("a" + n);
		else if (n < 52)
			return 8'("A" + n - 26);
		return "_";
	endfunction

	function automatic logic [7:0] rand_word();
		if ($urandom_range(0, 3) == 0)
			return 8'("0" + $urandom_range(0, 9));
		return rand_letter();
	endfunction

	// printable filler, now and then a high byte; never q or backslash
	function automatic logic [7:0] rand_text(input logic [7:0] q);
		logic [7:0] c;
		c = 8'($urandom_range(8'h20, 8'h7E));
		if ($urandom_range(0, 15) == 0)
			c = 8'($urandom_range(128, 255));
		if (c == q || c == CH_BSL)
			c = "a";
		return c;
	endfunction

	task automatic flush_text();
		src_beat_t b;
		foreach (txt[i]) begin
			b.ch = txt[i];
			b.eot = (i == txt.size() - 1);
			src_q.push_back(b);
		end
		queued_beats += txt.size();
		txt.delete();
	endtask

	task automatic text_from(input string s);
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
	endtask

	// one text built from C-like fragments, cut at a random length
	task automatic add_text(input int max_len);
		int target;
		int k;
		int n;
		logic [7:0] q;
		string punct_set;
		punct_set = "~!%^&*()-+={[}]|:;<,>.?/#";
		target = $urandom_range(1, max_len);
		while (txt.size() < target) begin
			k = $urandom_range(0, 11);
			n = $urandom_range(0, 6);
			case (k)
				0, 1: begin
					txt.push_back(rand_letter());
					repeat (n) txt.push_back(rand_word());
				end
				2: begin
					txt.push_back(8'("0" + $urandom_range(0, 9)));
					repeat (n) txt.push_back(rand_word());
				end
				3: begin
					repeat ($urandom_range(1, 4)) begin
						case ($urandom_range(0, 2))
							0: txt.push_back(CH_SP);
							1: txt.push_back(CH_TAB);
							default: txt.push_back(CH_NL);
						endcase
					end
				end
				4, 5: begin
					q = (k == 4) ? CH_DQ : CH_SQ;
					txt.push_back(q);
					repeat (n) begin
						if ($urandom_range(0, 4) == 0) begin
							txt.push_back(CH_BSL);
							txt.push_back(8'($urandom_range(0, 255)));
						end else begin
							txt.push_back(rand_text(q));
						end
					end
					case ($urandom_range(0, 9))
						8: txt.push_back(CH_NL);
						9: ;
						default: txt.push_back(q);
					endcase
				end
				6: begin
					txt.push_back(CH_SLASH);
					txt.push_back(CH_SLASH);
					repeat (n) txt.push_back(rand_text(CH_NL));
					txt.push_back(CH_NL);
				end
				7: begin
					txt.push_back(CH_SLASH);
					txt.push_back(CH_STAR);
					repeat (n) begin
						case ($urandom_range(0, 4))
							0: txt.push_back(CH_STAR);
							1: txt.push_back(CH_SLASH);
							2: txt.push_back(CH_NL);
							3: txt.push_back(CH_SP);
							default: txt.push_back(rand_word());
						endcase
					end
					if ($urandom_range(0, 4) != 0) begin
						txt.push_back(CH_STAR);
						txt.push_back(CH_SLASH);
					end
				end
				8: begin
					txt.push_back(CH_NL);
					txt.push_back(CH_HASH);
					repeat (n + 2) begin
						if ($urandom_range(0, 5) == 0) begin
							txt.push_back(CH_BSL);
							txt.push_back(CH_NL);
						end else begin
							txt.push_back(rand_text(CH_NL));
						end
					end
					txt.push_back(CH_NL);
				end
				9: txt.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
				10: txt.push_back(8'($urandom_range(0, 255)));
				default: begin
					txt.push_back(CH_SLASH);
					txt.push_back(8'($urandom_range(0, 255)));
				end
			endcase
		end
		while (txt.size() > target)
			void'(txt.pop_back());
		flush_text();
	endtask

	task automatic queue_random(input int total);
		int goal;
		goal = queued_beats + total;
		while (queued_beats < goal)
			add_text(40);
	endtask

	// wait for input drained, all tokens back, then the pipeline tail
	task automatic settle();
		while (src_q.size() != 0 || in_valid)
			@(negedge clk);
		while (tok_q.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	always @(posedge clk) begin : drive_bytes
		src_beat_t nxt;
		logic offer;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			offer = in_valid;
			if (in_valid && s_ready) begin
				lex_byte(in_byte, in_last);
				offer = 1'b0;
			end
			if (!offer && src_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				nxt = src_q.pop_front();
				in_byte <= nxt.ch;
				in_last <= nxt.eot;
				offer = 1'b1;
			end
			in_valid <= offer;
		end
	end

	always @(posedge clk) begin : check_tokens
		token_t want;
		off_t got_start;
		off_t got_len;
		if (arst_n) begin
			if (m_valid && out_ready) begin
				got_start = m_data[31:0];
				got_len = m_data[63:32];
				if (tok_q.size() == 0) begin
					$error("unexpected token beat: start %0d length %0d", got_start, got_len);
					err_count++;
				end else begin
					want = tok_q.pop_front();
					if (m_user[3:0] !== want.kind) begin
						$error("token_kind: expected %0d, got %0d", want.kind, m_user[3:0]);
						err_count++;
					end
					if (got_start !== want.start) begin
						$error("token_start: expected %0d, got %0d", want.start, got_start);
						err_count++;
					end
					if (got_len !== want.len) begin
						$error("token_length: expected %0d, got %0d", want.len, got_len);
						err_count++;
					end
					if (m_last !== want.run_end) begin
						$error("run_final: expected %0d, got %0d", want.run_end, m_last);
						err_count++;
					end
					if (m_user[4] !== want.text_end) begin
						$error("text_final: expected %0d, got %0d", want.text_end, m_user[4]);
						err_count++;
					end
				end
			end
			if (long_stall_go && !stall_taken) begin
				stall_taken = 1'b1;
				stall_left = LONG_STALL;
			end
			if (stall_left > 0)
				stall_left--;
			out_ready <= (stall_left == 0) && ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && s_ready) || (m_valid && out_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("c_subset_byte_tokenizer test failed");
				$finish;
			end
		end
	end

	initial begin
		lexer_reset();
		src_idle_pct = 24;
		sink_idle_pct = 63;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// splice inside a directive line
		text_from("#a\\\nb\n");
		flush_text();
		// slash-star-slash stays open up to end of text
		text_from("/*/");
		flush_text();
		// K as a letter, escaped quote, char broken by newline
		text_from("K9 \"\\\"\"'x\n");
		flush_text();
		// extreme bytes, newline gives line start, open directive at end
		txt.push_back(8'h00);
		txt.push_back(8'hFF);
		text_from("\n#");
		flush_text();
		// hash off line start, line comment, lone slash as last byte
		text_from("7#//\n/");
		flush_text();
		settle();

		// receiver holds off while bytes keep coming, so the queue fills
		queue_random(400);
		long_stall_go = 1'b1;
		settle();

		src_idle_pct = 63;
		sink_idle_pct = 24;
		queue_random(400);
		settle();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		queue_random(400);
		settle();

		if (err_count == 0)
			$display("c_subset_byte_tokenizer test passed");
		else
			$display("c_subset_byte_tokenizer test failed");
		$finish;
	end

endmodule
